// File: design/button_pulse_rate_meter_top_defines.svh
// Assertion macros for the button pulse rate meter.
// Included by the RTL files that check their own logic; needs clk and rst_n in scope.
`ifndef BUTTON_PULSE_RATE_METER_TOP_DEFINES_SVH
`define BUTTON_PULSE_RATE_METER_TOP_DEFINES_SVH
`ifndef SYNTH
`define BPRM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPRM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define BPRM_ASSERT(label, prop, msg)
`define BPRM_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// File: design/bprm_pkg.sv
// Shared constants for the button pulse rate meter.
// No dependencies; imported by button_pulse_rate_meter_top, and bprm_div takes its parameter defaults from it.
package bprm_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int BTN_W          = 8;
    localparam int KIND_W         = 2;
    localparam int RATE_W         = 33;
    localparam int PRESSES_W      = 16;
    localparam int IDLE_W         = 16;
    localparam int MINP_W         = 8;
    localparam int SCALE_W        = 17;
    localparam int RATE_SCALE     = 100000;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 96;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDLE_W-1:0] IDLE_MS_RST     = 16'd200;
    localparam logic [MINP_W-1:0] MIN_PRESSES_RST = 8'd5;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_MS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESSES = 1'd1;

    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

    localparam logic [KIND_W-1:0] RK_LIVE  = 2'd0;
    localparam logic [KIND_W-1:0] RK_FINAL = 2'd1;
    localparam logic [KIND_W-1:0] RK_SHORT = 2'd2;
    localparam logic [KIND_W-1:0] RK_FEW   = 2'd3;

endpackage

// File: design/button_pulse_rate_meter_top.sv
// Button pulse rate meter: tracks one button and reports its press rate in centihertz.
// Path to the output handshake: EVAL then PUSH for a report without a rate; a report
// with a rate also passes MUL and DIV, where the divider produces one quotient bit a cycle.
// One item at a time: s_tready is low from EVAL until the FSM is back in IDLE, which
// includes any time spent in PUSH while the output register stays full and stalled.
// Reset (rst_n, asynchronous, active low) clears tracking and restores idle_ms 200, min 5.
`include "button_pulse_rate_meter_top_defines.svh"
module button_pulse_rate_meter_top #(
    parameter int COUNT_BITS = bprm_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bprm_pkg::S_TDATA_W-1:0]      s_tdata,   // button [7:0], time_ms [39:8]
    input  logic [bprm_pkg::KIND_W-1:0]         s_tuser,   // kind [1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bprm_pkg::M_TDATA_W-1:0]      m_tdata,   // button_res [7:0], rate_centihz [40:8],
                                                           // presses [56:41], window_ms [88:57]
    output logic [bprm_pkg::KIND_W-1:0]         m_tuser,   // report_kind [1:0]
    input  logic                                cfg_we,
    input  logic [bprm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bprm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bprm_pkg::*;

    localparam int NW    = COUNT_BITS + SCALE_W;
    localparam int QW    = (NW > RATE_W) ? NW : RATE_W;
    localparam int CXW   = COUNT_BITS + PRESSES_W;
    localparam int GEW   = COUNT_BITS + MINP_W;
    localparam int PAD_W = M_TDATA_W - (BTN_W + RATE_W + PRESSES_W + TIME_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [IDLE_W-1:0]     idle_ms_reg;
    logic [MINP_W-1:0]     min_presses_reg;
    logic                  tracking_reg, tracking_next;
    logic [BTN_W-1:0]      tracked_button_reg, tracked_button_next;
    logic [COUNT_BITS-1:0] press_total_reg, press_total_next;
    logic [TIME_W-1:0]     first_press_reg, first_press_next;
    logic [TIME_W-1:0]     last_press_reg, last_press_next;
    logic [TIME_W-1:0]     last_act_reg, last_act_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [KIND_W-1:0]     in_kind_reg;
    logic [BTN_W-1:0]      in_button_reg;
    logic [TIME_W-1:0]     in_time_reg;

    logic [KIND_W-1:0]     res_kind_reg, res_kind_next;
    logic [BTN_W-1:0]      res_button_reg, res_button_next;
    logic [RATE_W-1:0]     res_rate_reg, res_rate_next;
    logic [PRESSES_W-1:0]  res_presses_reg, res_presses_next;
    logic [TIME_W-1:0]     res_win_reg, res_win_next;
    logic [COUNT_BITS-1:0] cnt_m1_reg, cnt_m1_next;

    logic [KIND_W-1:0]     out_kind_reg;
    logic [BTN_W-1:0]      out_button_reg;
    logic [RATE_W-1:0]     out_rate_reg;
    logic [PRESSES_W-1:0]  out_presses_reg;
    logic [TIME_W-1:0]     out_win_reg;
    logic                  out_load;

    logic                  accept;
    logic [BTN_W-1:0]      eff_button;
    logic [COUNT_BITS-1:0] eff_cnt;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_res;
    logic [CXW-1:0]        cnt_wide;
    logic [PRESSES_W-1:0]  cnt_sat;
    logic [TIME_W-1:0]     first_new;
    logic [TIME_W-1:0]     win;
    logic [TIME_W-1:0]     idle_gap;
    logic                  btn_match;
    logic                  reach_min;
    logic                  is_down;

    logic                  div_start;
    logic                  div_done;
    logic [NW-1:0]         div_quo;
    logic [NW-1:0]         product;
    logic [QW-1:0]         q_ext;
    logic [RATE_W-1:0]     rate_sat;

    logic                  live_out;
    logic                  fail_out;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign is_down  = (in_kind_reg == KIND_DOWN);

    // a down with nothing tracked latches its own button
    assign eff_button = tracking_reg ? tracked_button_reg : in_button_reg;
    assign eff_cnt    = tracking_reg ? press_total_reg : '0;
    assign btn_match  = (in_button_reg == eff_button);
    assign cnt_inc    = (eff_cnt == {COUNT_BITS{1'b1}}) ? eff_cnt : eff_cnt + COUNT_BITS'(1);
    assign first_new  = (eff_cnt == '0) ? in_time_reg : first_press_reg;
    assign cnt_res    = is_down ? cnt_inc : press_total_reg;
    assign cnt_wide   = CXW'(cnt_res);
    assign cnt_sat    = ((cnt_wide >> PRESSES_W) != '0) ? {PRESSES_W{1'b1}}
                                                        : cnt_wide[PRESSES_W-1:0];
    assign win        = (is_down ? in_time_reg : last_press_reg)
                        - (is_down ? first_new : first_press_reg);
    assign idle_gap   = in_time_reg - last_act_reg;
    assign reach_min  = GEW'(cnt_inc) >= GEW'(min_presses_reg);

    assign product  = NW'(cnt_m1_reg) * NW'(RATE_SCALE);
    assign q_ext    = QW'(div_quo);
    assign rate_sat = ((q_ext >> RATE_W) != '0) ? {RATE_W{1'b1}} : q_ext[RATE_W-1:0];

    bprm_div #(
        .NW (NW),
        .DW (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (res_win_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next          = state_reg;
        tracking_next       = tracking_reg;
        tracked_button_next = tracked_button_reg;
        press_total_next    = press_total_reg;
        first_press_next    = first_press_reg;
        last_press_next     = last_press_reg;
        last_act_next       = last_act_reg;
        res_kind_next       = res_kind_reg;
        res_button_next     = res_button_reg;
        res_rate_next       = res_rate_reg;
        res_presses_next    = res_presses_reg;
        res_win_next        = res_win_reg;
        cnt_m1_next         = cnt_m1_reg;
        div_start           = 1'b0;
        out_load            = 1'b0;
        m_tvalid_next       = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next       = ST_IDLE;
                res_button_next  = eff_button;
                res_presses_next = cnt_sat;
                res_win_next     = win;
                res_rate_next    = '0;
                cnt_m1_next      = cnt_res - COUNT_BITS'(1);
                case (in_kind_reg)
                    KIND_DOWN:
                    begin
                        tracking_next       = 1'b1;
                        tracked_button_next = eff_button;
                        if (btn_match)
                        begin
                            first_press_next = first_new;
                            press_total_next = cnt_inc;
                            last_press_next  = in_time_reg;
                            last_act_next    = in_time_reg;
                            if (reach_min && win != '0)
                            begin
                                res_kind_next = RK_LIVE;
                                state_next    = ST_MUL;
                            end
                        end
                    end
                    KIND_UP:
                    begin
                        if (tracking_reg && btn_match)
                        begin
                            last_act_next = in_time_reg;
                        end
                    end
                    KIND_TICK:
                    begin
                        if (tracking_reg && press_total_reg != '0
                            && idle_gap > TIME_W'(idle_ms_reg))
                        begin
                            tracking_next    = 1'b0;
                            press_total_next = '0;
                            if (press_total_reg == COUNT_BITS'(1))
                            begin
                                res_kind_next = RK_FEW;
                                state_next    = ST_PUSH;
                            end
                            else if (win == '0)
                            begin
                                res_kind_next = RK_SHORT;
                                state_next    = ST_PUSH;
                            end
                            else
                            begin
                                res_kind_next = RK_FINAL;
                                state_next    = ST_MUL;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_rate_next = rate_sat;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            idle_ms_reg        <= IDLE_MS_RST;
            min_presses_reg    <= MIN_PRESSES_RST;
            tracking_reg       <= 1'b0;
            tracked_button_reg <= '0;
            press_total_reg    <= '0;
            first_press_reg    <= '0;
            last_press_reg     <= '0;
            last_act_reg       <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            tracking_reg       <= tracking_next;
            tracked_button_reg <= tracked_button_next;
            press_total_reg    <= press_total_next;
            first_press_reg    <= first_press_next;
            last_press_reg     <= last_press_next;
            last_act_reg       <= last_act_next;
            m_tvalid_reg       <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IDLE_MS:     idle_ms_reg     <= cfg_data[IDLE_W-1:0];
                    REG_MIN_PRESSES: min_presses_reg <= cfg_data[MINP_W-1:0];
                    default:         idle_ms_reg     <= idle_ms_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_kind_reg   <= s_tuser;
            in_button_reg <= s_tdata[BTN_W-1:0];
            in_time_reg   <= s_tdata[BTN_W +: TIME_W];
        end
        res_kind_reg    <= res_kind_next;
        res_button_reg  <= res_button_next;
        res_rate_reg    <= res_rate_next;
        res_presses_reg <= res_presses_next;
        res_win_reg     <= res_win_next;
        cnt_m1_reg      <= cnt_m1_next;
        if (out_load)
        begin
            out_kind_reg    <= res_kind_reg;
            out_button_reg  <= res_button_reg;
            out_rate_reg    <= res_rate_reg;
            out_presses_reg <= res_presses_reg;
            out_win_reg     <= res_win_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_win_reg, out_presses_reg, out_rate_reg, out_button_reg};

    assign live_out = m_tvalid_reg && (out_kind_reg == RK_LIVE);
    assign fail_out = m_tvalid_reg && (out_kind_reg == RK_SHORT || out_kind_reg == RK_FEW);

    `BPRM_ASSERT(a_idle_no_count, !tracking_reg |-> press_total_reg == '0, "count kept while idle")
    `BPRM_ASSERT(a_live_window, live_out |-> out_win_reg != '0, "live rate with empty window")
    `BPRM_ASSERT(a_final_zero_rate, fail_out |-> out_rate_reg == '0, "rate on a failed report")

endmodule

// File: design/bprm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses bprm_pkg for the time width; assertion macros from the defines header.
`include "button_pulse_rate_meter_top_defines.svh"
module bprm_div #(
    parameter int NW = bprm_pkg::COUNT_BITS_DEF + bprm_pkg::SCALE_W,
    parameter int DW = bprm_pkg::TIME_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dsr_reg;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift next dividend bit into the remainder, quotient bit into quo_reg
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `BPRM_ASSERT(a_div_no_restart, start |-> !busy_reg, "divider restarted while busy")
    `BPRM_ASSERT_NEXT(a_div_done_pulse, done_reg, !done_reg, "done held longer than a cycle")
    `BPRM_ASSERT(a_div_rem_bound, (busy_reg && dsr_reg != '0) |-> rem_reg < dsr_reg, "remainder out of range")

endmodule
